>>> design/vlqd_pkg.sv
// Shared types, constants and helpers for the source map mappings decoder.
package vlqd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int OUT_TDATA_W = 200;
    localparam int IN_TDATA_W = 8;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        KIND_SEGMENT = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_GENCOL   = 3'd1,
        ERR_NEG_GENCOL   = 3'd2,
        ERR_DESCENDING   = 3'd3,
        ERR_BAD_SRC      = 3'd4,
        ERR_NEG_SRC      = 3'd5,
        ERR_BAD_NAME     = 3'd6,
        ERR_NEG_NAME     = 3'd7
    } err_code_t;

    typedef struct packed {
        logic [63:0] vlq_accum;
        logic [6:0]  vlq_shift;
        logic        in_digit_run;
        logic [2:0]  field_number;
        logic        segment_pending;
        logic [63:0] column_sum;
        logic [63:0] source_sum;
        logic [63:0] line_sum;
        logic [63:0] origcol_sum;
        logic [63:0] name_sum;
        logic [31:0] line_counter;
        logic [31:0] prev_seg_column;
        logic        line_nonempty;
        logic        error_latched;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] gen_line;
        logic [31:0] gen_column;
        logic        has_source;
        logic [31:0] source_index;
        logic [31:0] orig_line;
        logic [31:0] orig_column;
        logic        has_name;
        logic [31:0] name_index;
        err_code_t   error_code;
        logic        last_of_run;
    } result_t;

    // {valid, value}
    function automatic logic [6:0] digit_decode(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic err_code_t bad_vlq_code(input logic [2:0] f);
        err_code_t r;
        if (f <= 3'd1) begin
            r = ERR_BAD_GENCOL;
        end
        else if (f >= 3'd5) begin
            r = ERR_BAD_NAME;
        end
        else begin
            r = ERR_BAD_SRC;
        end
        return r;
    endfunction

endpackage

>>> design/vlqd_step.sv
// Next-state and result logic for one character of the mappings string.
module vlqd_step (
    input  vlqd_pkg::state_t  cur,
    input  logic [7:0]        character,
    input  logic              final_char,
    output vlqd_pkg::state_t  nxt,
    output logic [1:0]        res_count,
    output vlqd_pkg::result_t res0,
    output vlqd_pkg::result_t res1
);

    function automatic vlqd_pkg::result_t make_res(
        input vlqd_pkg::kind_t     kind,
        input vlqd_pkg::err_code_t code,
        input logic                src,
        input logic                nm,
        input vlqd_pkg::state_t    st
    );
        vlqd_pkg::result_t r;
        r = '0;
        r.kind = kind;
        r.error_code = code;
        if (kind != vlqd_pkg::KIND_ERROR) begin
            r.gen_line = st.line_counter;
        end
        if (kind == vlqd_pkg::KIND_SEGMENT) begin
            r.gen_column = st.column_sum[31:0];
            if (src) begin
                r.has_source = 1'b1;
                r.source_index = st.source_sum[31:0];
                r.orig_line = st.line_sum[31:0];
                r.orig_column = st.origcol_sum[31:0];
            end
            if (nm) begin
                r.has_name = 1'b1;
                r.name_index = st.name_sum[31:0];
            end
        end
        return r;
    endfunction

    logic [6:0]  dig;
    logic        is_sep;
    logic        process;

    assign dig = vlqd_pkg::digit_decode(character);
    assign is_sep = (character == vlqd_pkg::CHAR_COMMA) || (character == vlqd_pkg::CHAR_SEMI);
    assign process = !cur.error_latched && !(final_char && character == vlqd_pkg::CHAR_NUL);

    always_comb
    begin
        logic [63:0]        acc;
        logic [6:0]         sh;
        logic [4:0]         chunk;
        logic [63:0]        mag;
        logic [63:0]        vval;
        logic [2:0]         f;
        logic [63:0]        operand;
        logic [63:0]        sum_new;
        logic               sep_path;
        logic               close_req;
        logic [1:0]         n;
        vlqd_pkg::result_t  r;

        nxt = cur;
        n = 2'd0;
        res0 = '0;
        res1 = '0;
        r = '0;
        acc = cur.vlq_accum;
        sh = cur.vlq_shift;
        chunk = dig[4:0];
        mag = '0;
        vval = '0;
        f = 3'(cur.field_number + 3'd1);
        operand = '0;
        sum_new = '0;
        sep_path = process && !dig[6] && !cur.in_digit_run && is_sep;

        if (process && dig[6]) begin
            if (!cur.in_digit_run) begin
                acc = '0;
                sh = '0;
            end
            nxt.in_digit_run = 1'b1;
            nxt.vlq_accum = acc;
            nxt.vlq_shift = sh;
            if (sh >= 7'd63 || (sh == 7'd60 && chunk[4:3] != 2'b00)) begin
                nxt.error_latched = 1'b1;
                r = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::bad_vlq_code(f), 1'b0, 1'b0, nxt);
                res0 = r;
                n = 2'd1;
            end
            else begin
                acc = acc | (64'(chunk) << sh);
                nxt.vlq_accum = acc;
                nxt.vlq_shift = 7'(sh + 7'd5);
                if (!dig[5]) begin
                    nxt.in_digit_run = 1'b0;
                    mag = {1'b0, acc[63:1]};
                    vval = acc[0] ? (~mag + 64'd1) : mag;
                    case (f)
                        3'd1:    operand = cur.column_sum;
                        3'd2:    operand = cur.source_sum;
                        3'd3:    operand = cur.line_sum;
                        3'd4:    operand = cur.origcol_sum;
                        default: operand = cur.name_sum;
                    endcase
                    sum_new = operand + vval;
                    if (f == 3'd1) begin
                        nxt.column_sum = sum_new;
                        if (sum_new[63]) begin
                            nxt.error_latched = 1'b1;
                            res0 = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::ERR_NEG_GENCOL,
                                            1'b0, 1'b0, nxt);
                            n = 2'd1;
                        end
                        else if (cur.line_nonempty &&
                                 sum_new < {32'd0, cur.prev_seg_column}) begin
                            nxt.error_latched = 1'b1;
                            res0 = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::ERR_DESCENDING,
                                            1'b0, 1'b0, nxt);
                            n = 2'd1;
                        end
                        else begin
                            nxt.prev_seg_column = sum_new[31:0];
                            nxt.line_nonempty = 1'b1;
                            nxt.segment_pending = 1'b1;
                            nxt.field_number = 3'd1;
                        end
                    end
                    else if (f <= 3'd4) begin
                        if (f == 3'd2) begin
                            nxt.source_sum = sum_new;
                        end
                        else if (f == 3'd3) begin
                            nxt.line_sum = sum_new;
                        end
                        else begin
                            nxt.origcol_sum = sum_new;
                        end
                        nxt.field_number = f;
                        if (f == 3'd4 && (cur.source_sum[63] || cur.line_sum[63] ||
                                          sum_new[63])) begin
                            nxt.error_latched = 1'b1;
                            res0 = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::ERR_NEG_SRC,
                                            1'b0, 1'b0, nxt);
                            n = 2'd1;
                        end
                    end
                    else begin
                        nxt.name_sum = sum_new;
                        if (sum_new[63]) begin
                            nxt.error_latched = 1'b1;
                            res0 = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::ERR_NEG_NAME,
                                            1'b0, 1'b0, nxt);
                            n = 2'd1;
                        end
                        else begin
                            res0 = make_res(vlqd_pkg::KIND_SEGMENT, vlqd_pkg::ERR_NONE,
                                            1'b1, 1'b1, nxt);
                            n = 2'd1;
                            nxt.segment_pending = 1'b0;
                            nxt.field_number = 3'd0;
                        end
                    end
                end
            end
        end
        else if (process && !sep_path) begin
            nxt.error_latched = 1'b1;
            res0 = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::bad_vlq_code(f), 1'b0, 1'b0, nxt);
            n = 2'd1;
        end

        // segment close on a separator or at the end of the string
        close_req = sep_path ||
                    (final_char && !nxt.error_latched && !nxt.in_digit_run);
        if (close_req && nxt.segment_pending) begin
            if (nxt.field_number == 3'd2 || nxt.field_number == 3'd3) begin
                nxt.error_latched = 1'b1;
                r = make_res(vlqd_pkg::KIND_ERROR, vlqd_pkg::ERR_BAD_SRC, 1'b0, 1'b0, nxt);
            end
            else begin
                r = make_res(vlqd_pkg::KIND_SEGMENT, vlqd_pkg::ERR_NONE,
                             nxt.field_number == 3'd4, 1'b0, nxt);
                nxt.segment_pending = 1'b0;
                nxt.field_number = 3'd0;
            end
            if (n == 2'd0) begin
                res0 = r;
            end
            else begin
                res1 = r;
            end
            n = 2'(n + 2'd1);
        end

        if (sep_path && character == vlqd_pkg::CHAR_SEMI && !nxt.error_latched) begin
            nxt.line_counter = 32'(nxt.line_counter + 32'd1);
            nxt.column_sum = '0;
            nxt.line_nonempty = 1'b0;
        end

        if (final_char && !nxt.error_latched) begin
            if (nxt.in_digit_run) begin
                nxt.error_latched = 1'b1;
                r = make_res(vlqd_pkg::KIND_ERROR,
                             vlqd_pkg::bad_vlq_code(3'(nxt.field_number + 3'd1)),
                             1'b0, 1'b0, nxt);
            end
            else begin
                r = make_res(vlqd_pkg::KIND_END, vlqd_pkg::ERR_NONE, 1'b0, 1'b0, nxt);
            end
            if (n == 2'd0) begin
                res0 = r;
            end
            else begin
                res1 = r;
            end
            n = 2'(n + 2'd1);
        end

        if (final_char) begin
            nxt = '0;
        end

        if (n == 2'd1) begin
            res0.last_of_run = 1'b1;
        end
        else if (n == 2'd2) begin
            res1.last_of_run = 1'b1;
        end
        res_count = n;
    end

endmodule

>>> design/vlqd_out_fifo.sv
// Result queue that takes up to two results per cycle and delivers one per cycle while ready is high.
module vlqd_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  vlqd_pkg::result_t push0,
    input  vlqd_pkg::result_t push1,
    output logic              room,
    output logic              valid,
    input  logic              ready,
    output vlqd_pkg::result_t head
);

    localparam int PTR_W = $clog2(vlqd_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(vlqd_pkg::FIFO_DEPTH + 1);

    vlqd_pkg::result_t mem [vlqd_pkg::FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign valid = (count_reg != '0);
    assign pop = valid && ready;
    assign room = (count_reg <= CNT_W'(vlqd_pkg::FIFO_DEPTH - 2));
    assign head = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push_count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next = CNT_W'(count_reg + CNT_W'(push_count) - CNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/vlq_mapping_stream_decoder_top.sv
// Top level of the streaming source map mappings decoder.
// Takes one mappings-string character per transaction on the slave side, one per cycle
// when the result queue has room for two entries, and returns segment, end-of-map and
// error transactions on the master side, one per cycle while m_tready is high. Each
// character is decoded by one 64-bit add and compare behind the decoder state register;
// results reach the master side through the result queue. A character causes at most
// two results (the last one marked by tlast), so a stream of those slows input to the
// output rate of one transaction per cycle. After the first error, input is ignored
// up to the character flagged final; that character returns the decoder to reset.
module vlq_mapping_stream_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // character
    input  logic         s_tlast,   // final_char
    output logic         m_tvalid,
    input  logic         m_tready,
    // gen_line, gen_column, has_source, source_index, orig_line, orig_column,
    // has_name, name_index, error_code, zero pad
    output logic [199:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast    // last_of_run
);

    vlqd_pkg::state_t  state_reg, state_next;
    vlqd_pkg::state_t  step_nxt;
    vlqd_pkg::result_t res0, res1, head;
    logic [1:0]        step_count;
    logic [1:0]        push_count;
    logic              accept;

    assign accept = s_tvalid && s_tready;
    assign push_count = accept ? step_count : 2'd0;
    assign state_next = accept ? step_nxt : state_reg;

    vlqd_step u_step (
        .cur        (state_reg),
        .character  (s_tdata),
        .final_char (s_tlast),
        .nxt        (step_nxt),
        .res_count  (step_count),
        .res0       (res0),
        .res1       (res1)
    );

    vlqd_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (s_tready),
        .valid      (m_tvalid),
        .ready      (m_tready),
        .head       (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign m_tdata = {3'd0, head.error_code, head.name_index, head.has_name,
                      head.orig_column, head.orig_line, head.source_index,
                      head.has_source, head.gen_column, head.gen_line};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=>
            (!state_reg.error_latched && !state_reg.in_digit_run &&
             state_reg.line_counter == 32'd0 && state_reg.field_number == 3'd0))
        else $error("decoder state not reset after final character");

    a_pending_fields: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.segment_pending == (state_reg.field_number != 3'd0))
        else $error("segment pending flag disagrees with field count");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && step_count != 2'd0) |=> m_tvalid)
        else $error("result of accepted character not presented");

endmodule
